[hw/rtl/range_remap_table_unit_assert.svh]
// Assertion macros for the range remap table unit.
`ifndef RANGE_REMAP_TABLE_UNIT_ASSERT_SVH
`define RANGE_REMAP_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RRT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("range remap table assertion failed");
`define RRT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("range remap table forbidden condition");
`else
`define RRT_ASSERT(lbl, clk, rstn, prop)
`define RRT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

[hw/rtl/rrt_pkg.sv]
// Types and codes shared by the range remap table unit.
package rrt_pkg;

    localparam logic       CMD_MAP      = 1'b0;
    localparam logic       CMD_LOOKUP   = 1'b1;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_ZERO    = 3'd1;
    localparam logic [2:0] STAT_WRAP    = 3'd2;
    localparam logic [2:0] STAT_COLLIDE = 3'd3;
    localparam logic [2:0] STAT_NOSPACE = 3'd4;
    localparam logic [2:0] STAT_FULL    = 3'd5;
    localparam logic [2:0] STAT_MISS    = 3'd6;

    typedef struct packed {
        logic        command;
        logic [63:0] src_addr;
        logic [63:0] range_size;
        logic [63:0] range_tag;
        logic [63:0] start_offset;
        logic        replace_overlaps;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] xlat_addr;
        logic [63:0] tag_out;
        logic [63:0] offset_out;
        logic [63:0] mapped_span;
    } t_out;

    typedef struct packed {
        logic [63:0] real_base;
        logic [63:0] length;
        logic [63:0] tag;
        logic [63:0] off_base;
        logic [63:0] mapped_base;
        logic [63:0] free_after;
    } t_entry;

endpackage

[hw/rtl/range_remap_table_unit.sv]
// Range remap table: ordered range table in one memory, driven by a sequencer.
//
// Input channel i_valid/o_ready carries a t_in item: a map command or a lookup.
// Output channel o_valid/i_ready carries one t_out result for every item.
// The block handles one item at a time; o_ready is high only while idle, so the
// next item is taken in the cycle after the result transfer at the earliest.
// Every table access sets an address, then takes the registered read data of
// the table memory, so the latency follows the entry count N. The steps:
//   lookup: reads the entries in order until a hit, or all N on a miss.
//   map: a collision scan, the table-full check, a compaction pass, then one
//   start step per piece and up to three placements, each a first-fit scan of
//   the entries, a shift of the later entries and a write of the new entry.
// Rejected maps (zero size, wrap, collision, full) end after the failing pass.
// Every result closes with reads of the first and last entries for the mapped
// span; an empty table skips them.
// Reset empties the table at once (count to zero); no clearing pass runs.
// A stalled receiver holds the result in the output register and the block
// takes no new item until the result transfer completes.
module range_remap_table_unit
    import rrt_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_L_RD, S_L_EV, S_M_RD, S_M_EV, S_M_NEED, S_C_RD, S_C_EV,
        S_C_FLUSH, S_P_START, S_P_RD, S_P_EV, S_I_RD, S_I_WR, S_S0, S_S1,
        S_S2, S_OUT
    } t_state;

    t_state          r_state;
    t_in             r_in;
    t_out            r_out;
    logic            r_out_v;
    logic [63:0]     r_last;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;
    logic            r_found;
    logic [CW-1:0]   r_ndel;
    t_entry          r_old;
    logic [63:0]     r_gb;
    logic [63:0]     r_ga;
    logic [CW-1:0]   r_w;
    t_entry          r_hold;
    logic            r_hold_v;
    logic [1:0]      r_piece;
    t_entry          r_new;
    logic [CW-1:0]   r_ins_pos;
    logic [CW-1:0]   r_sh;
    logic [63:0]     r_mb0;
    t_entry          r_rd;

    t_entry          mem [ENTRIES];

    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_entry          wr_data;

    logic [63:0]     in_last;
    logic [63:0]     e_last;
    logic            e_collide;
    logic [63:0]     m_gb;
    logic [63:0]     m_ga;
    logic [CW:0]     m_need;
    logic            pc_valid;
    logic [63:0]     pc_base;
    logic [63:0]     pc_len;
    logic [63:0]     pc_tag;
    logic [63:0]     pc_off;
    logic [CW-1:0]   cnt_m1;
    logic [CW-1:0]   sh_m1;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    assign in_last   = i_data.src_addr + i_data.range_size - 64'd1;
    assign e_last    = r_rd.real_base + r_rd.length - 64'd1;
    assign e_collide = (r_rd.real_base <= r_last) && (e_last >= r_in.src_addr);
    assign cnt_m1    = r_count - CW'(1);
    assign sh_m1     = r_sh - CW'(1);

    assign m_gb   = r_in.src_addr - r_old.real_base;
    assign m_ga   = (r_old.real_base + r_old.length) - (r_in.src_addr + r_in.range_size);
    assign m_need = r_found
        ? ((CW+1)'(r_count) - (CW+1)'(r_ndel) + (CW+1)'(m_gb != 64'd0)
           + (CW+1)'(m_ga != 64'd0))
        : ((CW+1)'(r_count) - (CW+1)'(r_ndel) + (CW+1)'(1));

    // The before piece, the new range and the after piece, in placement order.
    always_comb begin
        pc_valid = 1'b1;
        pc_base  = r_in.src_addr;
        pc_len   = r_in.range_size;
        pc_tag   = r_in.range_tag;
        pc_off   = r_in.start_offset;
        case (r_piece)
            2'd0: begin
                pc_valid = r_found && (r_gb != 64'd0);
                pc_base  = r_old.real_base;
                pc_len   = r_gb;
                pc_tag   = r_old.tag;
                pc_off   = r_old.off_base;
            end
            2'd2: begin
                pc_valid = r_found && (r_ga != 64'd0);
                pc_base  = r_in.src_addr + r_in.range_size;
                pc_len   = r_ga;
                pc_tag   = r_old.tag;
                pc_off   = r_old.off_base + r_gb + r_in.range_size;
            end
            default: begin
                pc_valid = (r_piece == 2'd1);
            end
        endcase
    end

    always_comb begin
        rd_addr = r_idx[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_w[AW-1:0];
        wr_data = r_hold;
        unique case (r_state)
            S_I_RD: begin
                rd_addr = sh_m1[AW-1:0];
                if (r_sh == r_ins_pos) begin
                    wr_en   = 1'b1;
                    wr_addr = r_ins_pos[AW-1:0];
                    wr_data = r_new;
                end
            end
            S_I_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_sh[AW-1:0];
                wr_data = r_rd;
            end
            S_C_EV: begin
                wr_en = !e_collide && r_hold_v;
            end
            S_C_FLUSH: begin
                wr_en = r_hold_v;
            end
            S_P_EV: begin
                // The entry that gives up its free space keeps none.
                if (!((r_idx == '0) && (r_rd.mapped_base >= r_new.length))
                    && (r_rd.free_after >= r_new.length)) begin
                    wr_en              = 1'b1;
                    wr_addr            = r_idx[AW-1:0];
                    wr_data            = r_rd;
                    wr_data.free_after = 64'd0;
                end
            end
            S_S0:    rd_addr = '0;
            S_S1:    rd_addr = cnt_m1[AW-1:0];
            default: rd_addr = r_idx[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_out_v  <= 1'b0;
            r_count  <= '0;
            r_hold_v <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in                <= i_data;
                        r_last              <= in_last;
                        r_out.xlat_addr     <= '0;
                        r_out.tag_out       <= '0;
                        r_out.offset_out    <= '0;
                        r_out.mapped_span   <= '0;
                        r_idx               <= '0;
                        r_found             <= 1'b0;
                        r_ndel              <= '0;
                        if (i_data.command == CMD_LOOKUP) begin
                            r_out.status <= STAT_MISS;
                            r_state      <= S_L_RD;
                        end else if (i_data.range_size == 64'd0) begin
                            r_out.status <= STAT_ZERO;
                            r_state      <= S_S0;
                        end else if (in_last < i_data.src_addr) begin
                            r_out.status <= STAT_WRAP;
                            r_state      <= S_S0;
                        end else begin
                            r_out.status <= STAT_OK;
                            r_state      <= S_M_RD;
                        end
                    end
                end
                S_L_RD: begin
                    r_state <= (r_idx == r_count) ? S_S0 : S_L_EV;
                end
                S_L_EV: begin
                    if ((r_in.src_addr >= r_rd.real_base) && (r_in.src_addr <= e_last)) begin
                        r_out.status     <= STAT_OK;
                        r_out.xlat_addr  <= r_rd.mapped_base + (r_in.src_addr - r_rd.real_base);
                        r_out.tag_out    <= r_rd.tag;
                        r_out.offset_out <= (r_in.src_addr - r_rd.real_base) + r_rd.off_base;
                        r_state          <= S_S0;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_L_RD;
                    end
                end
                S_M_RD: begin
                    r_state <= (r_idx == r_count) ? S_M_NEED : S_M_EV;
                end
                S_M_EV: begin
                    if (e_collide && !r_in.replace_overlaps) begin
                        r_out.status <= STAT_COLLIDE;
                        r_state      <= S_S0;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_M_RD;
                        if (e_collide) begin
                            if (!r_found && (r_rd.real_base <= r_in.src_addr)
                                && (e_last >= r_last)
                                && (r_rd.length > r_in.range_size)) begin
                                r_found <= 1'b1;
                                r_old   <= r_rd;
                            end else begin
                                r_ndel <= r_ndel + CW'(1);
                            end
                        end
                    end
                end
                S_M_NEED: begin
                    r_gb <= m_gb;
                    r_ga <= m_ga;
                    if (m_need > (CW+1)'(ENTRIES)) begin
                        r_out.status <= STAT_FULL;
                        r_state      <= S_S0;
                    end else begin
                        r_idx    <= '0;
                        r_w      <= '0;
                        r_hold_v <= 1'b0;
                        r_state  <= S_C_RD;
                    end
                end
                S_C_RD: begin
                    r_state <= (r_idx == r_count) ? S_C_FLUSH : S_C_EV;
                end
                S_C_EV: begin
                    // A removed entry hands its space to the last kept one.
                    if (e_collide) begin
                        if (r_hold_v) begin
                            r_hold.free_after <= r_hold.free_after + r_rd.length
                                                 + r_rd.free_after;
                        end
                    end else begin
                        if (r_hold_v) begin
                            r_w <= r_w + CW'(1);
                        end
                        r_hold   <= r_rd;
                        r_hold_v <= 1'b1;
                    end
                    r_idx   <= r_idx + CW'(1);
                    r_state <= S_C_RD;
                end
                S_C_FLUSH: begin
                    r_count  <= r_w + CW'(r_hold_v);
                    r_hold_v <= 1'b0;
                    r_piece  <= 2'd0;
                    r_state  <= S_P_START;
                end
                S_P_START: begin
                    if (r_piece == 2'd3) begin
                        r_out.status <= STAT_OK;
                        r_state      <= S_S0;
                    end else if (!pc_valid) begin
                        r_piece <= r_piece + 2'd1;
                    end else begin
                        r_new.real_base <= pc_base;
                        r_new.length    <= pc_len;
                        r_new.tag       <= pc_tag;
                        r_new.off_base  <= pc_off;
                        r_idx           <= '0;
                        if (r_count == '0) begin
                            r_new.mapped_base <= 64'd0;
                            r_new.free_after  <= ~pc_len;
                            r_ins_pos         <= '0;
                            r_sh              <= '0;
                            r_state           <= S_I_RD;
                        end else begin
                            r_state <= S_P_RD;
                        end
                    end
                end
                S_P_RD: begin
                    r_state <= S_P_EV;
                end
                S_P_EV: begin
                    if ((r_idx == '0) && (r_rd.mapped_base >= r_new.length)) begin
                        r_new.mapped_base <= 64'd0;
                        r_new.free_after  <= r_rd.mapped_base - r_new.length;
                        r_ins_pos         <= '0;
                        r_sh              <= r_count;
                        r_state           <= S_I_RD;
                    end else if (r_rd.free_after >= r_new.length) begin
                        r_new.mapped_base <= r_rd.mapped_base + r_rd.length;
                        r_new.free_after  <= r_rd.free_after - r_new.length;
                        r_ins_pos         <= r_idx + CW'(1);
                        r_sh              <= r_count;
                        r_state           <= S_I_RD;
                    end else if ((r_idx + CW'(1)) == r_count) begin
                        r_out.status <= STAT_NOSPACE;
                        r_state      <= S_S0;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_P_RD;
                    end
                end
                S_I_RD: begin
                    if (r_sh == r_ins_pos) begin
                        r_count <= r_count + CW'(1);
                        r_piece <= r_piece + 2'd1;
                        r_state <= S_P_START;
                    end else begin
                        r_state <= S_I_WR;
                    end
                end
                S_I_WR: begin
                    r_sh    <= sh_m1;
                    r_state <= S_I_RD;
                end
                S_S0: begin
                    if (r_count == '0) begin
                        r_out.mapped_span <= 64'd0;
                        r_out_v           <= 1'b1;
                        r_state           <= S_OUT;
                    end else begin
                        r_state <= S_S1;
                    end
                end
                S_S1: begin
                    r_mb0   <= r_rd.mapped_base;
                    r_state <= S_S2;
                end
                S_S2: begin
                    r_out.mapped_span <= r_rd.mapped_base + r_rd.length - r_mb0;
                    r_out_v           <= 1'b1;
                    r_state           <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_out_v <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "range_remap_table_unit_assert.svh"

    `RRT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(ENTRIES))
    `RRT_NEVER(a_busy_while_result, i_clk, i_rst_n, o_valid && o_ready)
    `RRT_ASSERT(a_no_early_result, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_valid)
    `RRT_NEVER(a_hold_idle, i_clk, i_rst_n, r_hold_v && (r_state == S_P_START))

endmodule

[test/tb_range_remap_table_unit.sv]
// Self-checking testbench for the range remap table unit: maps and lookups against a predictor.
module tb_range_remap_table_unit;
    import rrt_pkg::*;

    localparam int DEPTH = 64;
    localparam int PEND = 1024;
    localparam logic [63:0] ALL_ONES = '1;
    localparam logic [63:0] HALF = 64'h8000_0000_0000_0000;

    class remap_scoreboard;
        t_entry      tbl[DEPTH];
        int          cnt;
        t_out        expected_results[PEND];
        int          n_noted;
        int          n_checked;
        int          errors;

        function new();
            cnt = 0;
            n_noted = 0;
            n_checked = 0;
            errors = 0;
        endfunction

        // Removing an entry hands its length and free space to the one before it.
        function void drop(int p);
            if (p >= cnt) return;
            if (p > 0) tbl[p-1].free_after += tbl[p].length + tbl[p].free_after;
            for (int i = p; i + 1 < cnt; i++) tbl[i] = tbl[i+1];
            cnt--;
        endfunction

        function void put(int p, t_entry e);
            if (cnt >= DEPTH || p > cnt) return;
            for (int i = cnt; i > p; i--) tbl[i] = tbl[i-1];
            tbl[p] = e;
            cnt++;
        endfunction

        // First-fit placement in the mapped space.
        function logic [2:0] fit(logic [63:0] base, logic [63:0] len,
                                 logic [63:0] tag, logic [63:0] off);
            logic [63:0] mb;
            logic [63:0] fa;
            if (cnt >= DEPTH) return STAT_FULL;
            if (cnt == 0) begin
                put(0, '{base, len, tag, off, 64'd0, ALL_ONES - len});
                return STAT_OK;
            end
            if (tbl[0].mapped_base >= len) begin
                put(0, '{base, len, tag, off, 64'd0, tbl[0].mapped_base - len});
                return STAT_OK;
            end
            for (int i = 0; i < cnt; i++) begin
                if (tbl[i].free_after < len) continue;
                mb = tbl[i].mapped_base + tbl[i].length;
                fa = tbl[i].free_after - len;
                tbl[i].free_after = 0;
                put(i + 1, '{base, len, tag, off, mb, fa});
                return STAT_OK;
            end
            return STAT_NOSPACE;
        endfunction

        function logic [2:0] map_range(logic [63:0] base, logic [63:0] len,
                                       logic [63:0] tag, logic [63:0] off, logic rep);
            bit          del[DEPTH];
            bit          found;
            int          old, ndel, shift, need, n, oldpos;
            logic [63:0] last, eb, el, gb, ga, ob, ol, ot, oo;
            logic [2:0]  st;
            found = 0;
            old = 0;
            ndel = 0;
            shift = 0;
            if (len == 0) return STAT_ZERO;
            last = base + len - 1;
            if (last < base) return STAT_WRAP;
            for (int i = 0; i < cnt; i++) begin
                eb = tbl[i].real_base;
                el = eb + tbl[i].length - 1;
                del[i] = 0;
                if (!(eb <= last && el >= base)) continue;
                if (!rep) return STAT_COLLIDE;
                if (!found && eb <= base && el >= last && tbl[i].length > len) begin
                    found = 1;
                    old = i;
                    continue;
                end
                del[i] = 1;
                ndel++;
            end
            if (found) begin
                gb = base - tbl[old].real_base;
                ga = (tbl[old].real_base + tbl[old].length) - (base + len);
                need = cnt - ndel + (gb != 0) + (ga != 0);
            end else begin
                need = cnt - ndel + 1;
            end
            if (need > DEPTH) return STAT_FULL;
            n = cnt;
            oldpos = old;
            for (int i = 0; i < n; i++) begin
                if (!del[i]) continue;
                if (found && i < old) oldpos--;
                drop(i - shift);
                shift++;
            end
            old = oldpos;
            if (!found) return fit(base, len, tag, off);
            // A strictly larger covering range is split around the new one.
            ob = tbl[old].real_base;
            ol = tbl[old].length;
            ot = tbl[old].tag;
            oo = tbl[old].off_base;
            gb = base - ob;
            ga = (ob + ol) - (base + len);
            drop(old);
            if (gb != 0) begin
                st = fit(ob, gb, ot, oo);
                if (st != STAT_OK) return st;
            end
            st = fit(base, len, tag, off);
            if (st != STAT_OK) return st;
            if (ga != 0) return fit(base + len, ga, ot, oo + gb + len);
            return STAT_OK;
        endfunction

        function t_out translate(t_in it);
            t_out        r;
            logic [63:0] eb, el;
            r = '0;
            if (it.command == CMD_LOOKUP) begin
                r.status = STAT_MISS;
                for (int i = 0; i < cnt; i++) begin
                    eb = tbl[i].real_base;
                    el = eb + tbl[i].length - 1;
                    if (it.src_addr >= eb && it.src_addr <= el) begin
                        r.xlat_addr = tbl[i].mapped_base + (it.src_addr - eb);
                        r.tag_out = tbl[i].tag;
                        r.offset_out = (it.src_addr - eb) + tbl[i].off_base;
                        r.status = STAT_OK;
                        break;
                    end
                end
            end else begin
                r.status = map_range(it.src_addr, it.range_size, it.range_tag,
                                     it.start_offset, it.replace_overlaps);
            end
            if (cnt > 0)
                r.mapped_span = tbl[cnt-1].mapped_base + tbl[cnt-1].length
                                - tbl[0].mapped_base;
            return r;
        endfunction

        function void note_input(t_in it);
            expected_results[n_noted % PEND] = translate(it);
            n_noted++;
        endfunction

        function void cmp(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_out got);
            t_out e;
            if (n_checked == n_noted) begin
                $display("%0t: unexpected result, actual %h", $time, got);
                errors++;
                return;
            end
            e = expected_results[n_checked % PEND];
            n_checked++;
            cmp("status", 64'(e.status), 64'(got.status));
            cmp("xlat_addr", e.xlat_addr, got.xlat_addr);
            cmp("tag_out", e.tag_out, got.tag_out);
            cmp("offset_out", e.offset_out, got.offset_out);
            cmp("mapped_span", e.mapped_span, got.mapped_span);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;
    bit   quiet;

    remap_scoreboard sb;

    range_remap_table_unit #(.ENTRIES(DEPTH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(negedge i_clk) begin
        i_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 22);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task send(t_in it);
        while (!quiet && $urandom_range(0, 99) < 22) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(it);
        @(negedge i_clk);
    endtask

    function logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task map_cmd(logic [63:0] addr, logic [63:0] size, logic [63:0] tag, logic rep);
        t_in it;
        it.command = CMD_MAP;
        it.src_addr = addr;
        it.range_size = size;
        it.range_tag = tag;
        it.start_offset = rand64();
        it.replace_overlaps = rep;
        send(it);
    endtask

    task lookup(logic [63:0] addr);
        t_in it;
        it = '0;
        it.command = CMD_LOOKUP;
        it.src_addr = addr;
        it.range_size = rand64();
        it.range_tag = rand64();
        it.start_offset = rand64();
        it.replace_overlaps = $urandom_range(0, 1);
        send(it);
    endtask

    initial begin
        #(8 * 3_000_000);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int unsigned region;
        int unsigned r;
        sb = new();
        quiet = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: limits of size and address, collisions, splits and no space.
        lookup(64'd0);
        map_cmd(64'd0, 64'd0, rand64(), 1'b1);
        map_cmd(ALL_ONES, 64'd2, rand64(), 1'b1);
        map_cmd(ALL_ONES, 64'd1, ALL_ONES, 1'b0);
        map_cmd(64'd0, HALF, 64'd0, 1'b0);
        map_cmd(HALF, HALF - 1, rand64(), 1'b0);
        map_cmd(64'd0, 64'd4, rand64(), 1'b0);
        map_cmd(64'd16, 64'd16, rand64(), 1'b1);
        lookup(64'd20);
        lookup(64'd0);
        lookup(64'd40);
        lookup(ALL_ONES);
        lookup(HALF);
        map_cmd(64'd8, 64'd16, rand64(), 1'b1);
        lookup(64'd10);
        map_cmd(64'd0, ALL_ONES, rand64(), 1'b1);
        lookup(64'd123);
        map_cmd(64'd16, 64'd1, rand64(), 1'b1);
        lookup(64'd16);
        lookup(64'd17);
        lookup(ALL_ONES - 1);
        map_cmd(64'd0, ALL_ONES, rand64(), 1'b1);

        // Random part: dense traffic in a small address window so the table fills,
        // collides and splits, with some full-width noise.
        region = 8192;
        for (int k = 0; k < 400; k++) begin
            quiet = (k >= 150 && k < 250);
            if (k % 100 == 0) region = ($urandom_range(0, 1) != 0) ? 8192 : 65536;
            r = $urandom_range(0, 99);
            if (r < 48)
                map_cmd(64'($urandom_range(0, region - 1)),
                        ($urandom_range(0, 49) == 0) ? 64'd0 : 64'($urandom_range(1, 48)),
                        ($urandom_range(0, 9) == 0) ? ALL_ONES : rand64(),
                        $urandom_range(0, 9) != 0);
            else if (r < 86)
                lookup(64'($urandom_range(0, region + 63)));
            else if (r < 92)
                map_cmd(rand64(), rand64() >> $urandom_range(0, 63), rand64(),
                        $urandom_range(0, 1));
            else if (r < 97)
                lookup(rand64());
            else if (r < 99)
                map_cmd(64'd0, 64'(region) + 64, rand64(), 1'b1);
            else
                map_cmd(ALL_ONES - 64'($urandom_range(0, 15)), 64'($urandom_range(1, 32)),
                        rand64(), $urandom_range(0, 1));
        end
        i_valid <= 1'b0;

        while (sb.n_checked != sb.n_noted) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
